@@ rtl/awt_pkg.sv @@
package awt_pkg;

    // longest word that is streamed; longer words report overflow
    localparam int MAX_WORD_LENGTH = 256;

    // word counter also holds the overflow mark MAX_WORD_LENGTH + 1
    localparam int COUNT_W    = $clog2(MAX_WORD_LENGTH + 2);
    localparam int WORD_LEN_W = 9;
    localparam int LINE_W     = 32;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_COMMENT,
        PH_WORD,
        PH_ESCAPE
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_EMPTY,
        ST_QMARK,
        ST_OVERFLOW,
        ST_EOF
    } status_t;

    typedef enum logic {
        KIND_CHAR,
        KIND_END
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic [7:0]              char_out;
        logic [7:0]              delimiter;
        logic [WORD_LEN_W-1:0]   word_length;
        status_t                 status;
        logic [LINE_W-1:0]       line_number;
        logic                    last;
    } result_t;

endpackage

@@ rtl/awt_if.sv @@
interface awt_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       end_of_file;
    logic       qmark_allowed;
    logic       period_allowed;

    modport source (
        output valid, char_in, end_of_file, qmark_allowed, period_allowed,
        input  ready
    );
    modport sink (
        input  valid, char_in, end_of_file, qmark_allowed, period_allowed,
        output ready
    );
endinterface

interface awt_token_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  char_out;
    logic [7:0]  delimiter;
    logic [8:0]  word_length;
    logic [2:0]  status;
    logic [31:0] line_number;
    logic        last;

    modport source (
        output valid, kind, char_out, delimiter, word_length, status, line_number, last,
        input  ready
    );
    modport sink (
        input  valid, kind, char_out, delimiter, word_length, status, line_number, last,
        output ready
    );
endinterface

@@ rtl/attribute_word_tokenizer.sv @@
// Word lexer for attribute files: one character enters per item on chars and
// the word stream leaves on tokens. Whitespace and bar comments before a word
// are skipped, characters of a word come out one item each (escaped by a
// backslash where needed, space and tab runs folded to one space, trailing
// ones dropped), and every word closes with an end item carrying delimiter,
// length and status. A character is taken in every cycle in which the queue
// has room; the lexer state is updated in the accepting cycle and its results
// land in a four-entry result queue, so a character that releases a folded
// space plus itself pushes two items. chars.ready is low while the queue holds
// more than two items, which makes the sustained rate one character per cycle
// as long as tokens is drained at one item per cycle. line_number in every
// result is the line count as it stood before the character that caused it.
module attribute_word_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    awt_char_if.sink    chars,
    awt_token_if.source tokens
);
    import awt_pkg::*;

    phase_t               phase_reg, phase_next;
    logic                 pend_reg, pend_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic                 fq_reg, fq_next;
    logic [LINE_W-1:0]    line_reg, line_next;

    logic                 accept;
    logic                 room;
    logic [7:0]           ch;
    logic                 eof;
    logic                 qa;
    logic                 pa;
    logic                 white;
    logic                 delim;

    logic                 do_flush;
    logic                 do_store;
    logic                 do_finish;
    logic                 inc_line;
    logic                 to_comment;
    logic [7:0]           fin_delim;
    logic [1:0]           n_v;
    result_t              res_a;
    result_t              res_b;
    result_t              item;
    result_t              out_data;
    logic                 out_valid;
    logic [1:0]           push_cnt;

    assign ch  = chars.char_in;
    assign eof = chars.end_of_file;
    assign qa  = chars.qmark_allowed;
    assign pa  = chars.period_allowed;

    assign white = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL)
                || (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);
    assign delim = (ch == CH_COMMA) || (ch == CH_COLON) || (ch == CH_BAR)
                || (ch == CH_NL) || ((ch == CH_PERIOD) && !pa);

    assign chars.ready = room;
    assign accept      = chars.valid && room;

    // per-character decisions
    always_comb
    begin
        do_flush   = 1'b0;
        do_store   = 1'b0;
        do_finish  = 1'b0;
        inc_line   = 1'b0;
        to_comment = 1'b0;
        fin_delim  = CH_NUL;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        unique case (phase_reg)
            PH_SKIP:
            begin
                if (eof)
                begin
                    do_finish = 1'b1;
                end
                else if (ch == CH_BAR)
                begin
                    phase_next = PH_COMMENT;
                end
                else if (white)
                begin
                    inc_line = (ch == CH_NL);
                end
                else if (delim)
                begin
                    do_finish = 1'b1;
                    fin_delim = ch;
                end
                else
                begin
                    phase_next = PH_WORD;
                    if (ch == CH_BSLASH)
                    begin
                        do_flush   = 1'b1;
                        phase_next = PH_ESCAPE;
                    end
                    else
                    begin
                        do_flush = 1'b1;
                        do_store = 1'b1;
                    end
                end
            end
            PH_COMMENT:
            begin
                if (eof)
                begin
                    inc_line  = 1'b1;
                    do_finish = 1'b1;
                end
                else if (ch == CH_NL)
                begin
                    inc_line   = 1'b1;
                    phase_next = PH_SKIP;
                end
            end
            PH_WORD:
            begin
                if (eof)
                begin
                    do_finish = 1'b1;
                end
                else if (delim)
                begin
                    do_finish  = 1'b1;
                    fin_delim  = ch;
                    inc_line   = (ch == CH_NL);
                    to_comment = (ch == CH_BAR);
                end
                else if (ch == CH_BSLASH)
                begin
                    do_flush   = 1'b1;
                    phase_next = PH_ESCAPE;
                end
                else if ((ch == CH_SPACE) || (ch == CH_TAB))
                begin
                    pend_next = 1'b1;
                end
                else
                begin
                    do_flush = 1'b1;
                    do_store = 1'b1;
                end
            end
            PH_ESCAPE:
            begin
                if (eof)
                begin
                    do_finish = 1'b1;
                end
                else
                begin
                    do_store   = 1'b1;
                    phase_next = PH_WORD;
                end
            end
            default:
            begin
                phase_next = PH_SKIP;
            end
        endcase

        // result slots, counter and question mark flag
        item             = '0;
        item.line_number = line_reg;
        res_a            = item;
        res_b            = item;
        n_v              = 2'd0;
        cnt_next         = cnt_reg;
        fq_next          = fq_reg;

        // folded space goes out ahead of the character
        if (do_flush && pend_reg)
        begin
            pend_next = 1'b0;
            if (cnt_next < COUNT_W'(MAX_WORD_LENGTH))
            begin
                if (cnt_next == '0)
                begin
                    fq_next = 1'b0;
                end
                item.kind     = KIND_CHAR;
                item.char_out = CH_SPACE;
                res_a         = item;
                n_v           = 2'd1;
                cnt_next      = cnt_next + COUNT_W'(1);
            end
            else
            begin
                cnt_next = COUNT_W'(MAX_WORD_LENGTH + 1);
            end
        end

        // the character itself
        if (do_store)
        begin
            if (cnt_next < COUNT_W'(MAX_WORD_LENGTH))
            begin
                if (cnt_next == '0)
                begin
                    fq_next = (ch == CH_QMARK);
                end
                item.kind     = KIND_CHAR;
                item.char_out = ch;
                if (n_v == 2'd0)
                begin
                    res_a = item;
                end
                else
                begin
                    res_b = item;
                end
                n_v      = n_v + 2'd1;
                cnt_next = cnt_next + COUNT_W'(1);
            end
            else
            begin
                cnt_next = COUNT_W'(MAX_WORD_LENGTH + 1);
            end
        end

        // end of word item, never shares an item with characters
        if (do_finish)
        begin
            item.kind      = KIND_END;
            item.char_out  = CH_NUL;
            item.delimiter = fin_delim;
            if (cnt_reg > COUNT_W'(MAX_WORD_LENGTH))
            begin
                item.word_length = WORD_LEN_W'(MAX_WORD_LENGTH);
            end
            else
            begin
                item.word_length = WORD_LEN_W'(cnt_reg);
            end
            priority if (eof)
            begin
                item.status = ST_EOF;
            end
            else if (cnt_reg > COUNT_W'(MAX_WORD_LENGTH))
            begin
                item.status = ST_OVERFLOW;
            end
            else if ((cnt_reg == '0) && !pa)
            begin
                item.status = ST_EMPTY;
            end
            else if (!qa && (cnt_reg == COUNT_W'(1)) && fq_reg)
            begin
                item.status = ST_QMARK;
            end
            else
            begin
                item.status = ST_OK;
            end
            res_a      = item;
            n_v        = 2'd1;
            cnt_next   = '0;
            pend_next  = 1'b0;
            fq_next    = 1'b0;
            phase_next = to_comment ? PH_COMMENT : PH_SKIP;
        end

        res_a.last = (n_v == 2'd1);
        res_b.last = 1'b1;

        // saturating line counter
        line_next = line_reg;
        if (inc_line && (line_reg != '1))
        begin
            line_next = line_reg + LINE_W'(1);
        end
    end

    assign push_cnt = accept ? n_v : 2'd0;

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            pend_reg  <= 1'b0;
            cnt_reg   <= '0;
            fq_reg    <= 1'b0;
            line_reg  <= LINE_W'(1);
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            fq_reg    <= fq_next;
            line_reg  <= line_next;
        end
    end

    // result queue
    awt_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_a    (res_a),
        .push_b    (res_b),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (tokens.ready),
        .out_data  (out_data)
    );

    assign tokens.valid       = out_valid;
    assign tokens.kind        = out_data.kind;
    assign tokens.char_out    = out_data.char_out;
    assign tokens.delimiter   = out_data.delimiter;
    assign tokens.word_length = out_data.word_length;
    assign tokens.status      = out_data.status;
    assign tokens.line_number = out_data.line_number;
    assign tokens.last        = out_data.last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= COUNT_W'(MAX_WORD_LENGTH + 1))
        else $error("word counter beyond overflow mark");

    a_pend_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (phase_reg == PH_WORD))
        else $error("pending space outside a word");

    a_fq_has_char: assert property (@(posedge clk) disable iff (!rst_n)
        fq_reg |-> (cnt_reg != '0))
        else $error("question mark flag without a stored character");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line counter wrapped to zero");

endmodule

@@ rtl/awt_out_fifo.sv @@
module awt_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_cnt,
    input  awt_pkg::result_t push_a,
    input  awt_pkg::result_t push_b,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output awt_pkg::result_t out_data
);
    import awt_pkg::*;

    result_t                 mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_reg;
    logic [FIFO_PTR_W-1:0]   rd_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_PTR_W-1:0]   wr_plus1;
    logic                    pop;

    assign wr_plus1  = wr_reg + FIFO_PTR_W'(1);
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_reg];
    assign pop       = out_valid && out_ready;
    // room for the two items one character can cause
    assign room      = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    // storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_reg] <= push_a;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_plus1] <= push_b;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_reg + FIFO_PTR_W'(push_cnt);
            rd_reg    <= rd_reg + FIFO_PTR_W'(pop);
            count_reg <= count_reg + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue fill level out of range");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != 2'd0) |-> room)
        else $error("result pushed without room");

    a_no_push_three: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd3)
        else $error("more than two results pushed at once");

endmodule
